>>> rtl/stl_pkg.sv
package stl_pkg;

  localparam int NWORDS = 33;
  localparam int MAX_KW_LEN = 10;
  localparam int LEN_W = 4;
  localparam logic [16:0] MAX_SRC = 17'd65536;
  localparam logic [16:0] POS_MAX = 17'd65536;

  localparam logic [5:0] K_SEMI = 6'd0;
  localparam logic [5:0] K_COMMA = 6'd1;
  localparam logic [5:0] K_LPAREN = 6'd2;
  localparam logic [5:0] K_RPAREN = 6'd3;
  localparam logic [5:0] K_STAR = 6'd4;
  localparam logic [5:0] K_EQ = 6'd5;
  localparam logic [5:0] K_LESS = 6'd6;
  localparam logic [5:0] K_LESSEQ = 6'd7;
  localparam logic [5:0] K_GREATER = 6'd8;
  localparam logic [5:0] K_GREATEREQ = 6'd9;
  localparam logic [5:0] K_NOTEQ = 6'd10;
  localparam logic [5:0] K_BOOL = 6'd41;
  localparam logic [5:0] K_NULL = 6'd42;
  localparam logic [5:0] K_IDENT = 6'd46;
  localparam logic [5:0] K_INT = 6'd43;
  localparam logic [5:0] K_DOUBLE = 6'd44;
  localparam logic [5:0] K_STRING = 6'd45;
  localparam logic [5:0] K_END = 6'd47;

  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_BANG = 3'd1;
  localparam logic [2:0] E_UNEXP = 3'd2;
  localparam logic [2:0] E_DOUBLE = 3'd3;
  localparam logic [2:0] E_STRING = 3'd4;

  typedef enum logic [3:0] {
    M_IDLE, M_LT, M_GT, M_BANG, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR
  } mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [16:0] start_line;
    logic [16:0] start_column;
    logic [15:0] start_offset;
    logic [15:0] text_length;
    logic [2:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  // up to three results from one request
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
    out_item_t  r2;
  } burst_t;

  // reserved word character at position p, upper case, 0 past the end
  function automatic logic [7:0] word_char(input logic [5:0] k, input logic [3:0] p);
    logic [79:0] s;
    case (k)
      6'd0: s = {"CREATE", 32'h0};
      6'd1: s = {"TABLE", 40'h0};
      6'd2: s = {"PRIMARY", 24'h0};
      6'd3: s = {"KEY", 56'h0};
      6'd4: s = {"UNIQUE", 32'h0};
      6'd5: s = {"DROP", 48'h0};
      6'd6: s = {"INDEX", 40'h0};
      6'd7: s = {"ON", 64'h0};
      6'd8: s = {"INSERT", 32'h0};
      6'd9: s = {"INTO", 48'h0};
      6'd10: s = {"VALUES", 32'h0};
      6'd11: s = {"SELECT", 32'h0};
      6'd12: s = {"FROM", 48'h0};
      6'd13: s = {"WHERE", 40'h0};
      6'd14: s = {"UPDATE", 32'h0};
      6'd15: s = {"SET", 56'h0};
      6'd16: s = {"DELETE", 32'h0};
      6'd17: s = {"BEGIN", 40'h0};
      6'd18: s = {"COMMIT", 32'h0};
      6'd19: s = {"ROLLBACK", 16'h0};
      6'd20: s = "CHECKPOINT";
      6'd21: s = {"INT8", 48'h0};
      6'd22: s = {"INT16", 40'h0};
      6'd23: s = {"INT32", 40'h0};
      6'd24: s = {"INT64", 40'h0};
      6'd25: s = {"DOUBLE", 32'h0};
      6'd26: s = {"STRING", 32'h0};
      6'd27: s = {"BOOL", 48'h0};
      6'd28: s = {"IS", 64'h0};
      6'd29: s = {"NOT", 56'h0};
      6'd30: s = {"TRUE", 48'h0};
      6'd31: s = {"FALSE", 40'h0};
      6'd32: s = {"NULL", 48'h0};
      default: s = 80'h0;
    endcase
    if (p > 4'd9) word_char = 8'h0;
    else word_char = s[79 - 8*p -: 8];
  endfunction

  function automatic logic [3:0] word_len(input logic [5:0] k);
    case (k)
      6'd7, 6'd28: word_len = 4'd2;
      6'd3, 6'd15, 6'd29: word_len = 4'd3;
      6'd5, 6'd9, 6'd12, 6'd21, 6'd27, 6'd30, 6'd32: word_len = 4'd4;
      6'd1, 6'd6, 6'd13, 6'd17, 6'd22, 6'd23, 6'd24, 6'd31: word_len = 4'd5;
      6'd2: word_len = 4'd7;
      6'd19: word_len = 4'd8;
      6'd20: word_len = 4'd10;
      default: word_len = 4'd6;
    endcase
  endfunction

  function automatic logic [5:0] word_kind(input logic [5:0] k);
    if (k == 6'd32) word_kind = K_NULL;
    else if (k == 6'd31) word_kind = K_BOOL;
    else word_kind = k + 6'd11;
  endfunction

endpackage

>>> rtl/stl_scan.sv
// Lexer state and the per-byte decision; produces a burst of results
module stl_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  stl_pkg::in_item_t item,
  output stl_pkg::burst_t   burst
);

  stl_pkg::mode_t mode, mode_next;
  logic [16:0] tok_off, tok_off_next;
  logic [16:0] tok_line, tok_line_next, tok_col, tok_col_next;
  logic [16:0] cur_off, cur_off_next, cur_line, cur_line_next, cur_col, cur_col_next;
  logic [stl_pkg::NWORDS-1:0] cand, cand_next;
  logic [stl_pkg::LEN_W-1:0] ilen, ilen_next;
  logic halted, halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stl_pkg::M_IDLE;
      tok_off <= '0; tok_line <= 17'd1; tok_col <= 17'd1;
      cur_off <= '0; cur_line <= 17'd1; cur_col <= 17'd1;
      cand <= '1; ilen <= '0; halted <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      tok_off <= tok_off_next; tok_line <= tok_line_next; tok_col <= tok_col_next;
      cur_off <= cur_off_next; cur_line <= cur_line_next; cur_col <= cur_col_next;
      cand <= cand_next; ilen <= ilen_next; halted <= halted_next;
    end
  end

  function automatic logic [15:0] sat16(input logic [16:0] v);
    sat16 = v[16] ? 16'hFFFF : v[15:0];
  endfunction

  always_comb begin
    logic [7:0] c, up;
    logic dig, let_c, wch, ok, to_idle;
    logic [16:0] off_a, line_a, col_a, d, len_s;
    logic [5:0] wkind;
    logic [1:0] n;
    stl_pkg::out_item_t r [3];
    stl_pkg::out_item_t t;

    c = item.char_code;
    up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    dig = c >= "0" && c <= "9";
    let_c = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    wch = let_c || dig || c == "_";

    mode_next = mode;
    tok_off_next = tok_off; tok_line_next = tok_line; tok_col_next = tok_col;
    cur_off_next = cur_off; cur_line_next = cur_line; cur_col_next = cur_col;
    cand_next = cand; ilen_next = ilen; halted_next = halted;
    n = 2'd0; ok = 1'b1; to_idle = 1'b0;
    len_s = '0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    t = '0;

    // cursor after this byte
    off_a = (cur_off < stl_pkg::MAX_SRC) ? cur_off + 17'd1 : cur_off;
    if (c == 8'h0A) begin
      line_a = (cur_line < stl_pkg::POS_MAX) ? cur_line + 17'd1 : cur_line;
      col_a = 17'd1;
    end else begin
      line_a = cur_line;
      col_a = (cur_col < stl_pkg::POS_MAX) ? cur_col + 17'd1 : cur_col;
    end

    // keyword match on the current candidate set
    wkind = stl_pkg::K_IDENT;
    for (int k = 0; k < stl_pkg::NWORDS; k++)
      if (cand[k] && stl_pkg::word_len(6'(k)) == ilen) wkind = stl_pkg::word_kind(6'(k));

    d = cur_off - tok_off;
    t.start_line = tok_line; t.start_column = tok_col; t.start_offset = sat16(tok_off);
    t.text_length = sat16(d);

    if (!halted && item.has_char) begin
      case (mode)
        stl_pkg::M_LT, stl_pkg::M_GT: begin
          mode_next = stl_pkg::M_IDLE;
          if (c == "=") begin
            t.text_length = sat16(off_a - tok_off);
            t.token_kind = (mode == stl_pkg::M_LT) ? stl_pkg::K_LESSEQ : stl_pkg::K_GREATEREQ;
            r[0] = t; n = 2'd1;
            cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
          end else begin
            t.token_kind = (mode == stl_pkg::M_LT) ? stl_pkg::K_LESS : stl_pkg::K_GREATER;
            r[0] = t; n = 2'd1; to_idle = 1'b1;
          end
        end
        stl_pkg::M_BANG: begin
          if (c != "=") begin
            t.token_kind = stl_pkg::K_END; t.text_length = '0; t.error_code = stl_pkg::E_BANG;
            r[0] = t; n = 2'd1; ok = 1'b0;
          end else begin
            t.text_length = sat16(off_a - tok_off);
            t.token_kind = stl_pkg::K_NOTEQ; r[0] = t; n = 2'd1;
            mode_next = stl_pkg::M_IDLE;
            cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
          end
        end
        stl_pkg::M_IDENT: begin
          if (wch) begin
            cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
            for (int k = 0; k < stl_pkg::NWORDS; k++)
              if (ilen >= stl_pkg::word_len(6'(k)) ||
                  stl_pkg::word_char(6'(k), ilen) != up) cand_next[k] = 1'b0;
            if (ilen <= 4'(stl_pkg::MAX_KW_LEN)) ilen_next = ilen + 4'd1;
          end else begin
            t.token_kind = wkind; r[0] = t; n = 2'd1; to_idle = 1'b1;
          end
        end
        stl_pkg::M_INT: begin
          if (dig) begin
            cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
          end else if (c == ".") begin
            cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
            mode_next = stl_pkg::M_DOT;
          end else begin
            t.token_kind = stl_pkg::K_INT; r[0] = t; n = 2'd1; to_idle = 1'b1;
          end
        end
        stl_pkg::M_DOT: begin
          if (!dig) begin
            t.token_kind = stl_pkg::K_END; t.text_length = '0; t.error_code = stl_pkg::E_DOUBLE;
            r[0] = t; n = 2'd1; ok = 1'b0;
          end else begin
            cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
            mode_next = stl_pkg::M_FRAC;
          end
        end
        stl_pkg::M_FRAC: begin
          if (dig) begin
            cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
          end else begin
            t.token_kind = stl_pkg::K_DOUBLE; r[0] = t; n = 2'd1; to_idle = 1'b1;
          end
        end
        stl_pkg::M_STR: begin
          cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
          if (c == 8'h27) begin
            len_s = off_a - tok_off;
            t.token_kind = stl_pkg::K_STRING;
            t.start_offset = sat16(tok_off + 17'd1);
            t.text_length = sat16((len_s >= 17'd2) ? len_s - 17'd2 : 17'd0);
            r[0] = t; n = 2'd1; mode_next = stl_pkg::M_IDLE;
          end
        end
        default: to_idle = 1'b1;
      endcase

      // byte seen with no token in progress, or after the token it ends
      if (to_idle) begin
        mode_next = stl_pkg::M_IDLE;
        tok_off_next = cur_off; tok_line_next = cur_line; tok_col_next = cur_col;
        cur_off_next = off_a; cur_line_next = line_a; cur_col_next = col_a;
        t.start_line = cur_line; t.start_column = cur_col; t.start_offset = sat16(cur_off);
        // one byte long unless the cursor has stopped at the source limit
        t.text_length = sat16(off_a - cur_off); t.error_code = stl_pkg::E_NONE;
        if (c == ";" || c == "," || c == "(" || c == ")" || c == "*" || c == "=") begin
          case (c)
            ";": t.token_kind = stl_pkg::K_SEMI;
            ",": t.token_kind = stl_pkg::K_COMMA;
            "(": t.token_kind = stl_pkg::K_LPAREN;
            ")": t.token_kind = stl_pkg::K_RPAREN;
            "*": t.token_kind = stl_pkg::K_STAR;
            default: t.token_kind = stl_pkg::K_EQ;
          endcase
          r[n] = t; n = n + 2'd1;
        end else if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
        end else if (c == "<") mode_next = stl_pkg::M_LT;
        else if (c == ">") mode_next = stl_pkg::M_GT;
        else if (c == "!") mode_next = stl_pkg::M_BANG;
        else if (c == 8'h27) mode_next = stl_pkg::M_STR;
        else if (dig) mode_next = stl_pkg::M_INT;
        else if (wch) begin
          mode_next = stl_pkg::M_IDENT;
          for (int k = 0; k < stl_pkg::NWORDS; k++)
            cand_next[k] = stl_pkg::word_char(6'(k), 4'd0) == up;
          ilen_next = 4'd1;
        end else begin
          t.token_kind = stl_pkg::K_END; t.text_length = '0; t.error_code = stl_pkg::E_UNEXP;
          r[n] = t; n = n + 2'd1; ok = 1'b0;
        end
      end
      if (!ok) begin
        halted_next = 1'b1; mode_next = stl_pkg::M_IDLE;
      end
    end

    // end of source: pending token then end token, or its error if open
    if (!halted && ok && item.end_of_source) begin
      t = '0;
      t.start_line = tok_line_next; t.start_column = tok_col_next;
      t.start_offset = sat16(tok_off_next);
      t.text_length = sat16(cur_off_next - tok_off_next);
      case (mode_next)
        stl_pkg::M_LT: begin t.token_kind = stl_pkg::K_LESS; r[n] = t; n = n + 2'd1; end
        stl_pkg::M_GT: begin t.token_kind = stl_pkg::K_GREATER; r[n] = t; n = n + 2'd1; end
        stl_pkg::M_INT: begin t.token_kind = stl_pkg::K_INT; r[n] = t; n = n + 2'd1; end
        stl_pkg::M_FRAC: begin t.token_kind = stl_pkg::K_DOUBLE; r[n] = t; n = n + 2'd1; end
        stl_pkg::M_IDENT: begin
          t.token_kind = stl_pkg::K_IDENT;
          for (int k = 0; k < stl_pkg::NWORDS; k++)
            if (cand_next[k] && stl_pkg::word_len(6'(k)) == ilen_next)
              t.token_kind = stl_pkg::word_kind(6'(k));
          r[n] = t; n = n + 2'd1;
        end
        stl_pkg::M_BANG, stl_pkg::M_DOT, stl_pkg::M_STR: begin
          t.token_kind = stl_pkg::K_END; t.text_length = '0;
          t.error_code = (mode_next == stl_pkg::M_BANG) ? stl_pkg::E_BANG :
                         (mode_next == stl_pkg::M_DOT) ? stl_pkg::E_DOUBLE : stl_pkg::E_STRING;
          r[n] = t; n = n + 2'd1; ok = 1'b0;
          halted_next = 1'b1; mode_next = stl_pkg::M_IDLE;
        end
        default: ;
      endcase
      if (ok) begin
        t = '0;
        t.token_kind = stl_pkg::K_END;
        t.start_line = cur_line_next; t.start_column = cur_col_next;
        t.start_offset = sat16(cur_off_next);
        r[n] = t; n = n + 2'd1;
        mode_next = stl_pkg::M_IDLE;
        tok_off_next = '0; tok_line_next = 17'd1; tok_col_next = 17'd1;
        cur_off_next = '0; cur_line_next = 17'd1; cur_col_next = 17'd1;
        cand_next = '1; ilen_next = '0;
      end
    end

    case (n)
      2'd1: r[0].last_of_run = 1'b1;
      2'd2: r[1].last_of_run = 1'b1;
      2'd3: r[2].last_of_run = 1'b1;
      default: ;
    endcase
    burst.count = n; burst.r0 = r[0]; burst.r1 = r[1]; burst.r2 = r[2];
  end

endmodule

>>> rtl/stl_out.sv
// Holds a result burst and hands it out one result at a time
module stl_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  stl_pkg::burst_t     burst,
  output logic                empty_next,
  output logic                valid,
  input  logic                stall,
  output stl_pkg::out_item_t  item
);

  logic [1:0] count;
  stl_pkg::out_item_t q [3];
  logic take;

  assign take = valid && !stall;
  assign valid = count != 2'd0;
  assign item = q[0];
  // free once the last held result goes this cycle
  assign empty_next = (count == 2'd0) || (count == 2'd1 && take);

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (load) count <= burst.count;
    else if (take) count <= count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q[0] <= burst.r0; q[1] <= burst.r1; q[2] <= burst.r2;
    end else if (take) begin
      q[0] <= q[1]; q[1] <= q[2];
    end
  end

endmodule

>>> rtl/sql_token_lexer_core.sv
// Channel | Direction | Payload              | Handshake
// in      | input     | stl_pkg::in_item_t   | in_valid / in_stall
// out     | output    | stl_pkg::out_item_t  | out_valid / out_stall
// A byte request is taken in the cycle it arrives when the output queue is
// empty or drains its last result that cycle; its results appear the next cycle.
// One result leaves per cycle while out_stall is low, so a request with k
// results (up to 3) keeps in_stall high until the last of them is leaving.
// Rate is one byte per cycle for bytes with at most one result, out_stall low.
// Reset (rst, synchronous) returns cursor to line 1, column 1, offset 0,
// the scanner to idle, and clears the halt.
// out_stall holds the current result and backs up into in_stall in the same cycle.
module sql_token_lexer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  stl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output stl_pkg::out_item_t out_item
);

  stl_pkg::burst_t burst;
  logic empty_next, step;

  assign in_stall = !empty_next;
  assign step = in_valid && empty_next;

  stl_scan u_scan (
    .clk(clk), .rst(rst), .step(step), .item(in_item), .burst(burst)
  );

  stl_out u_out (
    .clk(clk), .rst(rst), .load(step), .burst(burst), .empty_next(empty_next),
    .valid(out_valid), .stall(out_stall), .item(out_item)
  );

endmodule

>>> tb/testbench.sv
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  stl_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  stl_pkg::out_item_t out_item;

  sql_token_lexer_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idling odds, in percent
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  stl_pkg::out_item_t token_q[$];

  // ---------------------------------------------------------------
  // Lexer state kept by the testbench
  // ---------------------------------------------------------------
  stl_pkg::mode_t lx_mode;
  int unsigned tok_off, tok_line, tok_col;
  int unsigned cur_off, cur_line, cur_col;
  logic [32:0] word_mask;
  int unsigned word_count;
  bit          lx_halted;

  string reserved[33] = '{
    "CREATE", "TABLE", "PRIMARY", "KEY", "UNIQUE", "DROP", "INDEX", "ON",
    "INSERT", "INTO", "VALUES", "SELECT", "FROM", "WHERE", "UPDATE", "SET",
    "DELETE", "BEGIN", "COMMIT", "ROLLBACK", "CHECKPOINT", "INT8", "INT16",
    "INT32", "INT64", "DOUBLE", "STRING", "BOOL", "IS", "NOT",
    "TRUE", "FALSE", "NULL"
  };

  function automatic logic [15:0] clip16(int unsigned v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [5:0] reserved_kind(int k);
    if (k == 32) return stl_pkg::K_NULL;
    if (k >= 30) return stl_pkg::K_BOOL;
    return 6'(k + 11);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function void lx_restart();
    lx_mode = stl_pkg::M_IDLE;
    tok_off = 0; tok_line = 1; tok_col = 1;
    cur_off = 0; cur_line = 1; cur_col = 1;
    word_mask = '1;
    word_count = 0;
  endfunction

  function void lx_advance(logic [7:0] c);
    if (cur_off < 65536) cur_off++;
    if (c == 8'h0A) begin
      if (cur_line < 65536) cur_line++;
      cur_col = 1;
    end else if (cur_col < 65536) begin
      cur_col++;
    end
  endfunction

  function void lx_mark();
    tok_off = cur_off; tok_line = cur_line; tok_col = cur_col;
  endfunction

  function void push_token(logic [5:0] kind, int unsigned line, int unsigned col,
                           logic [15:0] off, logic [15:0] len, logic [2:0] err);
    stl_pkg::out_item_t r;
    r.token_kind = kind;
    r.start_line = line[16:0];
    r.start_column = col[16:0];
    r.start_offset = off;
    r.text_length = len;
    r.error_code = err;
    r.last_of_run = 1'b0;
    token_q = {token_q, r};
  endfunction

  function void emit_plain(logic [5:0] kind);
    push_token(kind, tok_line, tok_col, clip16(tok_off), clip16(cur_off - tok_off),
               stl_pkg::E_NONE);
  endfunction

  function void emit_fault(logic [2:0] code);
    push_token(stl_pkg::K_END, tok_line, tok_col, clip16(tok_off), 16'd0, code);
    lx_halted = 1'b1;
    lx_mode = stl_pkg::M_IDLE;
  endfunction

  // narrow the reserved word candidates by one more letter
  function void word_letter(logic [7:0] c);
    logic [7:0] up;
    up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    for (int k = 0; k < 33; k++)
      if (word_count >= reserved[k].len() || reserved[k][word_count] != up)
        word_mask[k] = 1'b0;
    if (word_count <= 10) word_count++;
  endfunction

  function void emit_word();
    logic [5:0] kind;
    kind = stl_pkg::K_IDENT;
    for (int k = 0; k < 33; k++)
      if (word_mask[k] && reserved[k].len() == word_count) kind = reserved_kind(k);
    emit_plain(kind);
  endfunction

  function bit idle_char(logic [7:0] c);
    lx_mark();
    lx_advance(c);
    case (c)
      ";": begin emit_plain(stl_pkg::K_SEMI); return 1'b1; end
      ",": begin emit_plain(stl_pkg::K_COMMA); return 1'b1; end
      "(": begin emit_plain(stl_pkg::K_LPAREN); return 1'b1; end
      ")": begin emit_plain(stl_pkg::K_RPAREN); return 1'b1; end
      "*": begin emit_plain(stl_pkg::K_STAR); return 1'b1; end
      "=": begin emit_plain(stl_pkg::K_EQ); return 1'b1; end
      default: ;
    endcase
    if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) return 1'b1;
    if (c == "<") begin lx_mode = stl_pkg::M_LT; return 1'b1; end
    if (c == ">") begin lx_mode = stl_pkg::M_GT; return 1'b1; end
    if (c == "!") begin lx_mode = stl_pkg::M_BANG; return 1'b1; end
    if (c == "'") begin lx_mode = stl_pkg::M_STR; return 1'b1; end
    if (is_digit(c)) begin lx_mode = stl_pkg::M_INT; return 1'b1; end
    if (is_alpha(c) || c == "_") begin
      lx_mode = stl_pkg::M_IDENT;
      word_mask = '1;
      word_count = 0;
      word_letter(c);
      return 1'b1;
    end
    emit_fault(stl_pkg::E_UNEXP);
    return 1'b0;
  endfunction

  function bit lx_char(logic [7:0] c);
    case (lx_mode)
      stl_pkg::M_LT, stl_pkg::M_GT: begin
        bit lt;
        lt = (lx_mode == stl_pkg::M_LT);
        lx_mode = stl_pkg::M_IDLE;
        if (c == "=") begin
          lx_advance(c);
          emit_plain(lt ? stl_pkg::K_LESSEQ : stl_pkg::K_GREATEREQ);
          return 1'b1;
        end
        emit_plain(lt ? stl_pkg::K_LESS : stl_pkg::K_GREATER);
      end
      stl_pkg::M_BANG: begin
        if (c != "=") begin emit_fault(stl_pkg::E_BANG); return 1'b0; end
        lx_advance(c);
        lx_mode = stl_pkg::M_IDLE;
        emit_plain(stl_pkg::K_NOTEQ);
        return 1'b1;
      end
      stl_pkg::M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          lx_advance(c);
          word_letter(c);
          return 1'b1;
        end
        emit_word();
        lx_mode = stl_pkg::M_IDLE;
      end
      stl_pkg::M_INT: begin
        if (is_digit(c)) begin lx_advance(c); return 1'b1; end
        if (c == ".") begin lx_advance(c); lx_mode = stl_pkg::M_DOT; return 1'b1; end
        emit_plain(stl_pkg::K_INT);
        lx_mode = stl_pkg::M_IDLE;
      end
      stl_pkg::M_DOT: begin
        if (!is_digit(c)) begin emit_fault(stl_pkg::E_DOUBLE); return 1'b0; end
        lx_advance(c);
        lx_mode = stl_pkg::M_FRAC;
        return 1'b1;
      end
      stl_pkg::M_FRAC: begin
        if (is_digit(c)) begin lx_advance(c); return 1'b1; end
        emit_plain(stl_pkg::K_DOUBLE);
        lx_mode = stl_pkg::M_IDLE;
      end
      stl_pkg::M_STR: begin
        lx_advance(c);
        if (c == "'") begin
          int unsigned d;
          d = cur_off - tok_off;
          push_token(stl_pkg::K_STRING, tok_line, tok_col, clip16(tok_off + 1),
                     clip16(d >= 2 ? d - 2 : 0), stl_pkg::E_NONE);
          lx_mode = stl_pkg::M_IDLE;
        end
        return 1'b1;
      end
      default: lx_mode = stl_pkg::M_IDLE;
    endcase
    return idle_char(c);
  endfunction

  // end of source: pending token, then the end token
  function void lx_flush();
    case (lx_mode)
      stl_pkg::M_LT:    emit_plain(stl_pkg::K_LESS);
      stl_pkg::M_GT:    emit_plain(stl_pkg::K_GREATER);
      stl_pkg::M_BANG:  begin emit_fault(stl_pkg::E_BANG); return; end
      stl_pkg::M_IDENT: emit_word();
      stl_pkg::M_INT:   emit_plain(stl_pkg::K_INT);
      stl_pkg::M_DOT:   begin emit_fault(stl_pkg::E_DOUBLE); return; end
      stl_pkg::M_FRAC:  emit_plain(stl_pkg::K_DOUBLE);
      stl_pkg::M_STR:   begin emit_fault(stl_pkg::E_STRING); return; end
      default: ;
    endcase
    push_token(stl_pkg::K_END, cur_line, cur_col, clip16(cur_off), 16'd0, stl_pkg::E_NONE);
    lx_restart();
  endfunction

  // expected tokens for one accepted request
  function void predict_tokens(stl_pkg::in_item_t it);
    int  prior_count;
    bit  ok;
    prior_count = token_q.size();
    ok = 1'b1;
    if (lx_halted) return;
    if (it.has_char) ok = lx_char(it.char_code);
    if (ok && it.end_of_source) lx_flush();
    if (token_q.size() > prior_count) token_q[$].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------
  task automatic send_request(stl_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    predict_tokens(it);
  endtask

  task automatic send_byte(logic [7:0] c, bit eos);
    stl_pkg::in_item_t it;
    it.char_code = c;
    it.has_char = 1'b1;
    it.end_of_source = eos;
    send_request(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // result side stalls
  always @(negedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  // compare each result with the oldest expected token
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected result exp none got %h", $time, out_item);
        errors++;
      end else begin
        stl_pkg::out_item_t e;
        e = token_q.pop_front();
        if (out_item.token_kind !== e.token_kind)
          begin $display("%0t: token_kind exp %0d got %0d", $time, e.token_kind,
                         out_item.token_kind); errors++; end
        if (out_item.start_line !== e.start_line)
          begin $display("%0t: start_line exp %0d got %0d", $time, e.start_line,
                         out_item.start_line); errors++; end
        if (out_item.start_column !== e.start_column)
          begin $display("%0t: start_column exp %0d got %0d", $time, e.start_column,
                         out_item.start_column); errors++; end
        if (out_item.start_offset !== e.start_offset)
          begin $display("%0t: start_offset exp %0d got %0d", $time, e.start_offset,
                         out_item.start_offset); errors++; end
        if (out_item.text_length !== e.text_length)
          begin $display("%0t: text_length exp %0d got %0d", $time, e.text_length,
                         out_item.text_length); errors++; end
        if (out_item.error_code !== e.error_code)
          begin $display("%0t: error_code exp %0d got %0d", $time, e.error_code,
                         out_item.error_code); errors++; end
        if (out_item.last_of_run !== e.last_of_run)
          begin $display("%0t: last_of_run exp %0d got %0d", $time, e.last_of_run,
                         out_item.last_of_run); errors++; end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------
  typedef struct {
    stl_pkg::in_item_t it;
    bit                known;
    logic [5:0]        kind;
  } row_t;

  row_t rows[$];

  function void add_row(logic [7:0] c, bit has, bit eos, bit known = 0,
                        logic [5:0] kind = stl_pkg::K_END);
    row_t r;
    r.it.char_code = c;
    r.it.has_char = has;
    r.it.end_of_source = eos;
    r.known = known;
    r.kind = kind;
    rows = {rows, r};
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b1, 1'b0);
  endfunction

  function void build_rows();
    add_row(8'h00, 1'b0, 1'b1, 1'b1, stl_pkg::K_END);    // empty source
    add_row(8'hFF, 1'b0, 1'b0);                          // no byte, no end: nothing
    add_text("<");
    add_row("=", 1'b1, 1'b0, 1'b1, stl_pkg::K_LESSEQ);
    add_row(";", 1'b1, 1'b0, 1'b1, stl_pkg::K_SEMI);
    add_text(">");
    add_row("a", 1'b1, 1'b0, 1'b1, stl_pkg::K_GREATER);
    add_text("!");
    add_row("=", 1'b1, 1'b0, 1'b1, stl_pkg::K_NOTEQ);
    add_text(" Checkpoint");
    add_row("(", 1'b1, 1'b0, 1'b1, stl_pkg::K_LPAREN);
    add_text("_z9 12.5 'q");
    add_row(8'hFF, 1'b1, 1'b0);                          // high byte inside a string
    add_text("\n'");
    add_row("*", 1'b1, 1'b1, 1'b1, stl_pkg::K_END);
  endfunction

  // ---------------------------------------------------------------
  // Random sources
  // ---------------------------------------------------------------
  int unsigned rand_items = 0;
  logic [7:0]  src[$];

  function void src_put(logic [7:0] c);
    src = {src, c};
  endfunction

  function void add_lexeme();
    int sel;
    int n;
    logic [7:0] c;
    string ops[11] = '{";", ",", "(", ")", "*", "=", "<", "<=", ">", ">=", "!="};
    sel = $urandom_range(5);
    case (sel)
      0: begin
        string w;
        w = reserved[$urandom_range(32)];
        for (int i = 0; i < w.len(); i++)
          src_put($urandom_range(1) ? w[i] : (is_alpha(w[i]) ? 8'(w[i] + 8'd32) : w[i]));
      end
      1: begin
        src_put($urandom_range(3) == 0 ? "_" : 8'("a" + $urandom_range(25)));
        n = $urandom_range(3) == 0 ? $urandom_range(14) : $urandom_range(5);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(3))
            0: c = 8'("0" + $urandom_range(9));
            1: c = 8'("A" + $urandom_range(25));
            2: c = 8'("a" + $urandom_range(25));
            default: c = "_";
          endcase
          src_put(c);
        end
      end
      2: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) src_put(8'("0" + $urandom_range(9)));
      end
      3: begin
        // kept apart so a word or a double before it cannot swallow the digits
        src_put(" ");
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) src_put(8'("0" + $urandom_range(9)));
        src_put(".");
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) src_put(8'("0" + $urandom_range(9)));
      end
      4: begin
        src_put("'");
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
          c = 8'($urandom_range(255));
          if (c == "'") c = 8'h0A;
          src_put(c);
        end
        src_put("'");
      end
      default: begin
        string o;
        o = ops[$urandom_range(10)];
        for (int i = 0; i < o.len(); i++) src_put(o[i]);
      end
    endcase
    // separator, sometimes none so tokens run together
    case ($urandom_range(5))
      0: src_put(" ");
      1: src_put(8'h09);
      2: src_put(8'h0D);
      3: src_put(8'h0A);
      4: src_put(" ");
      default: ;
    endcase
  endfunction

  task automatic send_source();
    stl_pkg::in_item_t it;
    int ntok;
    src.delete();
    ntok = $urandom_range(7) == 0 ? 0 : $urandom_range(1, 7);
    for (int i = 0; i < ntok; i++) add_lexeme();
    foreach (src[i]) begin
      if ($urandom_range(15) == 0) begin
        it.char_code = 8'($urandom_range(255));
        it.has_char = 1'b0;
        it.end_of_source = 1'b0;
        send_request(it);
      end
      send_byte(src[i], (i == src.size() - 1) && $urandom_range(1));
      rand_items++;
      if ((i == src.size() - 1) && in_item.end_of_source) return;
    end
    it.char_code = 8'($urandom_range(255));
    it.has_char = 1'b0;
    it.end_of_source = 1'b1;
    send_request(it);
    rand_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (token_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    int          pidle[4] = '{0, 48, 0, 27};
    int          pstall[4] = '{0, 0, 48, 27};
    int unsigned fault;
    bit          drained;
    drained = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    lx_restart();
    lx_halted = 1'b0;
    build_rows();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows
    foreach (rows[i]) begin
      send_request(rows[i].it);
      if (rows[i].known && (token_q.size() == 0 || token_q[$].token_kind !== rows[i].kind))
        begin
          $display("%0t: directed row %0d exp kind %0d got %0d", $time, i, rows[i].kind,
                   token_q.size() ? token_q[$].token_kind : 6'd0);
          errors++;
        end
    end

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pidle[ph];
      stall_pct = pstall[ph];
      while (rand_items < 16 * (ph + 1)) begin
        send_source();
        if (ph == 2 && (!drained || $urandom_range(3) == 0)) begin
          wait_drained();
          drained = 1'b1;
        end
      end
    end

    // the first error halts the block: one kind per run
    fault = $urandom_range(3);
    case (fault)
      0: send_text("a !b");
      1: send_byte($urandom_range(1) ? 8'($urandom_range(128, 255)) : "#", 1'b0);
      2: send_text("7.x");
      default: begin
        send_text("'ab");
        send_byte("c", 1'b1);
      end
    endcase
    // ignored once halted
    send_text("x;");
    send_byte(";", 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && token_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sql_token_lexer_core.f
rtl/stl_pkg.sv
rtl/stl_scan.sv
rtl/stl_out.sv
rtl/sql_token_lexer_core.sv
tb/testbench.sv
